[rtl/svc_pkg.sv]
// Shared types and constants for the snapshot visibility checker.
package svc_pkg;

  // Default number of in-progress IDs that the table holds.
  localparam int TABLE_DEPTH_DEF = 64;

  // Widths of the word fields.
  localparam int ID_W      = 64;
  localparam int ACT_W     = 2;
  localparam int CNT_OUT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // Action codes carried by an input word.
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Input word.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  id_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                 visible;
    status_t              status;
    logic [CNT_OUT_W-1:0] entry_count_out;
  } out_word_t;

endpackage

[rtl/svc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module svc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/svc_ctrl.sv]
// Controller: decodes input words, scans the ID table through the RAM and builds results.
module svc_ctrl #(
  parameter int TABLE_DEPTH = svc_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  svc_pkg::in_word_t         in_word,
  input  logic [svc_pkg::ID_W-1:0]  lower_id,
  input  logic [svc_pkg::ID_W-1:0]  upper_id,
  output logic                      out_valid,
  output svc_pkg::out_word_t        out_word,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic [svc_pkg::ID_W-1:0]  ram_wdata,
  output logic                      ram_re,
  output logic [AW-1:0]             ram_raddr,
  input  logic [svc_pkg::ID_W-1:0]  ram_rdata
);

  import svc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_word_t         out_r, out_nxt;

  logic              accept;
  logic              below_lower;
  logic              below_upper;
  logic              in_window;
  logic              hit;
  logic              scan_done;
  logic              go_scan;

  assign accept      = start && (state_r == S_IDLE);
  assign below_lower = in_word.id_value < lower_id;
  assign below_upper = in_word.id_value < upper_id;
  assign in_window   = !below_lower && below_upper;

  // A hit compares the entry read in the previous cycle; the scan ends on a hit
  // or once every valid entry has been read and compared.
  assign hit       = cmp_vld_r && (ram_rdata == id_r);
  assign scan_done = hit || (idx_r == count_r);

  // Adds and queries that land inside the window need the table.
  assign go_scan = accept && in_window &&
                   ((in_word.action == ACT_ADD) || (in_word.action == ACT_QUERY));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (go_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM requests and result word.
  always_comb begin
    act_nxt     = act_r;
    id_nxt      = id_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    count_nxt   = count_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = id_r;
    ram_re      = 1'b0;
    ram_raddr   = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_word.action;
          id_nxt  = in_word.id_value;
          idx_nxt = '0;
          out_nxt.visible = 1'b0;
          out_nxt.status  = STAT_OK;
          out_nxt.entry_count_out = CNT_OUT_W'(count_r);
          case (in_word.action)
            ACT_CLEAR: begin
              count_nxt   = '0;
              out_vld_nxt = 1'b1;
              out_nxt.entry_count_out = '0;
            end
            ACT_ADD: begin
              if (!in_window) begin
                out_vld_nxt    = 1'b1;
                out_nxt.status = STAT_RANGE;
              end
            end
            ACT_QUERY: begin
              if (!in_window) begin
                out_vld_nxt     = 1'b1;
                out_nxt.visible = below_lower;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue the next read while entries remain.
        if (!scan_done && (idx_r < count_r)) begin
          ram_re      = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (scan_done) begin
          out_vld_nxt     = 1'b1;
          out_nxt.visible = 1'b0;
          out_nxt.status  = STAT_OK;
          out_nxt.entry_count_out = CNT_OUT_W'(count_r);
          if (act_r == ACT_QUERY) begin
            out_nxt.visible = !hit;
          end else if (hit) begin
            out_nxt.status = STAT_DUP;
          end else if (count_r >= DEPTH_CNT) begin
            out_nxt.status = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            out_nxt.entry_count_out = CNT_OUT_W'(count_nxt);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    id_r  <= id_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  // The count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count above table depth");

  // The scan index stays within the valid entries.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= count_r))
    else $error("scan index beyond entry count");

  // A table write happens only at the end of a scan and bumps the count by one.
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("table write without count increment");

  // Every accepted word either answers in the next cycle or starts a scan.
  a_accept_answer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_vld_r || (state_r == S_SCAN)))
    else $error("accepted word neither answered nor scanning");

  // A scan always ends with exactly one result.
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && scan_done) |=> (out_vld_r && (state_r == S_IDLE)))
    else $error("scan ended without a result");

endmodule

[rtl/snapshot_visibility_check_top.sv]
// Top level of the snapshot visibility checker: bound registers, controller and ID table.
//
//  Channel   Ports                               Transfer
//  input     start, busy, in_word                start high while busy low
//  result    out_valid, out_word                 one-cycle strobe, always taken
//  config    cfg_we, cfg_idx, cfg_data           write at any edge with cfg_we high
//
// A clear, an unused action, or an add or query with its ID outside [lower, upper) answers
// in the cycle after acceptance while busy stays low. An add or query inside the window
// scans the table through the one RAM read port, one entry per cycle, and busy stays high
// until a hit or until all count entries have been read and compared, count being the
// number of stored IDs. Reset zeroes the count and both bounds; the table needs no clearing
// pass since only entries below the count are read. The receiver cannot stall.
module snapshot_visibility_check_top #(
  parameter int TABLE_DEPTH = svc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  svc_pkg::in_word_t             in_word,
  output logic                          out_valid,
  output svc_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [svc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [svc_pkg::CFG_W-1:0]     cfg_data
);

  import svc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [ID_W-1:0] lower_r, lower_nxt;
  logic [ID_W-1:0] upper_r, upper_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ID_W-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [ID_W-1:0] ram_rdata;

  // Bound register writes.
  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LOWER: lower_nxt = cfg_data;
        CFG_UPPER: upper_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  // Controller.
  svc_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .lower_id  (lower_r),
    .upper_id  (upper_r),
    .out_valid (out_valid),
    .out_word  (out_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // In-progress ID table.
  svc_ram #(
    .WIDTH(ID_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[tb/sv/tb_snapshot_visibility_check_top.sv]
// Self-checking testbench for the snapshot visibility checker top level.
module tb_snapshot_visibility_check_top;
  import svc_pkg::*;

  // Kinds of entries in the stimulus queue.
  typedef enum logic [1:0] {
    OP_WORD,
    OP_CFG,
    OP_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t           kind;
    in_word_t             word;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } stim_op_t;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1450;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_word_t             in_word = '0;
  logic                 out_valid;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  stim_op_t  pending_q[$];
  out_word_t answer_q[$];
  int        words_taken = 0;
  int        answers_seen = 0;
  int        mismatches = 0;

  // Predictor copy of the snapshot.
  logic [ID_W-1:0] snap_lower = '0;
  logic [ID_W-1:0] snap_upper = '0;
  logic [ID_W-1:0] held_ids[DEPTH];
  int              held_count = 0;

  // Generator view of the bounds, used to aim IDs at the window.
  logic [ID_W-1:0] gen_lower = '0;
  logic [ID_W-1:0] gen_upper = '0;
  int              words_queued = 0;

  snapshot_visibility_check_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one word to the predicted snapshot state and return its answer.
  function automatic out_word_t predict_snapshot_answer(in_word_t w);
    out_word_t r;
    logic      hit;
    r = '0;
    r.status = STAT_OK;
    hit = 1'b0;
    for (int i = 0; i < held_count; i++) begin
      if (held_ids[i] == w.id_value) hit = 1'b1;
    end
    case (w.action)
      ACT_CLEAR: begin
        held_count = 0;
      end
      ACT_ADD: begin
        if (!(w.id_value >= snap_lower && w.id_value < snap_upper)) begin
          r.status = STAT_RANGE;
        end else if (hit) begin
          r.status = STAT_DUP;
        end else if (held_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          held_ids[held_count] = w.id_value;
          held_count++;
        end
      end
      ACT_QUERY: begin
        if (w.id_value < snap_lower) r.visible = 1'b1;
        else if (w.id_value >= snap_upper) r.visible = 1'b0;
        else r.visible = !hit;
      end
      default: ;
    endcase
    r.entry_count_out = held_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [ID_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // An ID inside [gen_lower, gen_upper), or a random one when the window is empty.
  function automatic logic [ID_W-1:0] id_in_window();
    if (gen_upper > gen_lower) return gen_lower + rand64() % (gen_upper - gen_lower);
    return rand64();
  endfunction

  function automatic logic [ID_W-1:0] id_near_edge();
    case ($urandom_range(0, 5))
      0: return gen_lower;
      1: return gen_lower - 1;
      2: return gen_upper;
      3: return gen_upper - 1;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic push_word(logic [ACT_W-1:0] act, logic [ID_W-1:0] id);
    stim_op_t op;
    op.kind = OP_WORD;
    op.word.action = act;
    op.word.id_value = id;
    op.idx = '0;
    op.data = '0;
    pending_q.push_back(op);
    words_queued++;
  endtask

  task automatic push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.word = '0;
    op.idx = '0;
    op.data = '0;
    pending_q.push_back(op);
  endtask

  task automatic set_window(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
    stim_op_t op;
    op.kind = OP_CFG;
    op.word = '0;
    op.idx = CFG_LOWER;
    op.data = lo;
    pending_q.push_back(op);
    op.idx = CFG_UPPER;
    op.data = hi;
    pending_q.push_back(op);
    gen_lower = lo;
    gen_upper = hi;
  endtask

  // One random phase: a pool of IDs mostly inside the window, then adds and
  // queries drawn from it, with clears, stray IDs and unused actions mixed in.
  task automatic run_phase(int pool_size, int add_pct, int n_words);
    logic [ID_W-1:0] pool[$];
    int              r;
    int              done;
    for (int i = 0; i < pool_size; i++) begin
      if ($urandom_range(0, 99) < 85) pool.push_back(id_in_window());
      else pool.push_back(id_near_edge());
    end
    if ($urandom_range(0, 99) < 70) push_word(ACT_CLEAR, rand64());
    done = 0;
    while (done < n_words && words_queued < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        push_word(ACT_ADD, pool[$urandom_range(0, pool_size - 1)]);
      end else if (r < 84) begin
        push_word(ACT_QUERY, pool[$urandom_range(0, pool_size - 1)]);
      end else if (r < 90) begin
        push_word($urandom_range(0, 1) ? ACT_ADD : ACT_QUERY,
                  $urandom_range(0, 1) ? id_near_edge() : rand64());
      end else if (r < 94) begin
        push_word(ACT_CLEAR, rand64());
      end else if (r < 97) begin
        push_word(2'd3, rand64());
      end else begin
        push_drain();
        done--;
      end
      done++;
    end
  endtask

  // Stimulus: reset, a directed pass, then random phases under several windows.
  initial begin
    int              phase;
    int              kind;
    int              big;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;

    // Reset bounds are both zero: the window is empty.
    push_word(ACT_QUERY, '0);
    push_word(ACT_ADD, 64'd5);
    push_word(2'd3, '1);
    push_word(ACT_CLEAR, '0);

    // Narrow window: boundaries, duplicate, hit and miss queries.
    set_window(64'd100, 64'd200);
    push_word(ACT_ADD, 64'd99);
    push_word(ACT_ADD, 64'd200);
    push_word(ACT_ADD, 64'd100);
    push_word(ACT_ADD, 64'd199);
    push_word(ACT_ADD, 64'd100);
    push_word(ACT_QUERY, 64'd99);
    push_word(ACT_QUERY, 64'd100);
    push_word(ACT_QUERY, 64'd150);
    push_word(ACT_QUERY, 64'd199);
    push_word(ACT_QUERY, 64'd200);
    push_word(ACT_QUERY, '1);
    push_word(2'd3, 64'd150);

    // Reversed bounds: every ID falls outside the window.
    push_drain();
    set_window('1, '0);
    push_word(ACT_ADD, 64'd150);
    push_word(ACT_QUERY, '0);
    push_word(ACT_QUERY, '1);

    // Widest window.
    set_window('0, '1);
    push_word(ACT_ADD, '0);
    push_word(ACT_QUERY, '0);
    push_word(ACT_ADD, '1);
    push_word(ACT_CLEAR, '1);
    push_word(ACT_QUERY, 64'd100);

    // Fill the table, then a new ID and a stored one against the full table.
    for (int i = 0; i < DEPTH; i++) push_word(ACT_ADD, 64'd1000 + 64'(i));
    push_word(ACT_ADD, 64'd5000);
    push_word(ACT_ADD, 64'd1000);
    push_word(ACT_QUERY, 64'd1000 + 64'(DEPTH - 1));
    push_word(ACT_QUERY, 64'd5000);
    push_word(ACT_CLEAR, '0);

    phase = 0;
    while (words_queued < RANDOM_WORDS) begin
      if (phase < 6) begin
        case (phase)
          0: kind = 0;
          1: kind = 1;
          2: kind = 5;
          3: kind = 2;
          4: kind = 3;
          default: kind = 4;
        endcase
      end else begin
        case ($urandom_range(0, 7))
          0, 1: kind = 0;
          2, 3: kind = 1;
          4, 5: kind = 5;
          6: kind = 2;
          default: kind = $urandom_range(3, 4);
        endcase
      end
      case (kind)
        0: begin lo = '0; hi = '1; end
        1: begin lo = rand64() >> 1; hi = lo + 64'($urandom_range(1, 150)); end
        2: begin lo = rand64(); hi = rand64(); end
        3: begin lo = rand64(); hi = lo; end
        4: begin lo = '1; hi = '1; end
        default: begin
          lo = 64'($urandom_range(0, 1000));
          hi = '1 - 64'($urandom_range(0, 1000));
        end
      endcase
      set_window(lo, hi);
      big = (kind == 0 || kind == 5) && $urandom_range(0, 1);
      if (big) run_phase(96, 72, $urandom_range(160, 220));
      else run_phase($urandom_range(0, 1) ? 6 : 30, 45, $urandom_range(70, 140));
      phase++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and answered, then let the block settle.
    while (pending_q.size() != 0 || start || words_taken != answers_seen) @(posedge clk);
    repeat (70) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("tb_snapshot_visibility_check_top: clean");
    end else begin
      $display("tb_snapshot_visibility_check_top: errors");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb_snapshot_visibility_check_top: errors");
    $finish;
  end

  // Driver: holds a word until it is taken, writes registers only when settled.
  always @(posedge clk) begin
    logic                 taken;
    logic                 settled;
    logic                 sender_idle;
    logic                 drive_start;
    in_word_t             next_word;
    logic                 next_we;
    logic [CFG_IDX_W-1:0] next_idx;
    logic [CFG_W-1:0]     next_data;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken = start && !busy;
      drive_start = start && !taken;
      next_word = in_word;
      next_we = 1'b0;
      next_idx = cfg_idx;
      next_data = cfg_data;
      // A long stretch in the middle of the run never idles.
      sender_idle = ($urandom_range(0, 99) < 10) && !(words_taken >= 400 && words_taken < 700);
      settled = !start && !busy && (words_taken == answers_seen);
      if (!drive_start && pending_q.size() != 0) begin
        case (pending_q[0].kind)
          OP_WORD: begin
            if (!sender_idle) begin
              drive_start = 1'b1;
              next_word = pending_q[0].word;
              void'(pending_q.pop_front());
            end
          end
          OP_CFG: begin
            if (settled) begin
              next_we = 1'b1;
              next_idx = pending_q[0].idx;
              next_data = pending_q[0].data;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (settled) void'(pending_q.pop_front());
          end
        endcase
      end
      if (taken) words_taken <= words_taken + 1;
      start <= drive_start;
      in_word <= next_word;
      cfg_we <= next_we;
      cfg_idx <= next_idx;
      cfg_data <= next_data;
    end
  end

  // Monitor: tracks register writes, checks each result word, predicts new ones.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_idx == CFG_LOWER) snap_lower = cfg_data;
        else if (cfg_idx == CFG_UPPER) snap_upper = cfg_data;
      end
      if (out_valid) begin
        answers_seen <= answers_seen + 1;
        if (answer_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_word);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (out_word.visible !== want.visible) begin
            $display("%0t: visible mismatch, expected %0b actual %0b",
                     $time, want.visible, out_word.visible);
            mismatches++;
          end
          if (out_word.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_word.status);
            mismatches++;
          end
          if (out_word.entry_count_out !== want.entry_count_out) begin
            $display("%0t: entry count mismatch, expected %0d actual %0d",
                     $time, want.entry_count_out, out_word.entry_count_out);
            mismatches++;
          end
        end
      end
      if (start && !busy) answer_q.push_back(predict_snapshot_answer(in_word));
    end
  end

endmodule
